FILE: rtl/core/srr_pkg.sv
// ============================================================================
// srr_pkg: shared types and constants of the selective-repeat receiver
// Window geometry, item structs, result kinds and sequencer states.
// ============================================================================
`default_nettype none

package srr_pkg;

  localparam int unsigned Window      = 16;
  localparam int unsigned SeqSpace    = 256;
  localparam int unsigned PayloadBits = 32;

  localparam int unsigned SeqW  = $clog2(SeqSpace);
  localparam int unsigned SlotW = $clog2(Window);

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_FIN  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DELIVER,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [7:0]  seq_num;
    logic        last_flag;
    logic [31:0] payload;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  seq_out;
    logic [31:0] data_out;
    logic        end_of_run;
  } out_item_t;

  typedef struct packed {
    logic                   last;
    logic [PayloadBits-1:0] payload;
  } slot_t;

endpackage

`default_nettype wire

FILE: rtl/core/selective_repeat_receiver_core.sv
// ============================================================================
// selective_repeat_receiver_core: selective-repeat receiver window
// Buffers in-window packets, acknowledges them and delivers payloads in order.
// ============================================================================
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------
//  input     | in_valid_i / in_stall_o   | in_item_i  (seq, last, data)
//  result    | out_valid_o / out_stall_i | out_item_o (kind, seq, data)
//  config    | cfg_we_i                  | cfg_data_i (start sequence)
//
// An item is acknowledged first; each in-order delivery then takes a memory
// read and an output load, and a fin follows the delivery with the last flag.
// The payload memory has a registered read, which sets these two steps.
// Reset clears the received marks, the base sequence and the finished flag.
// A new item is taken only when the sequencer is idle and the output
// register is free or being emptied in the same cycle.
`default_nettype none

module selective_repeat_receiver_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire srr_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output srr_pkg::out_item_t     out_item_o,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_data_i
);
  import srr_pkg::*;

  state_e             state_q, state_d;
  logic [SeqW-1:0]    base_q, base_d;
  logic [Window-1:0]  recv_q, recv_d;
  logic               finished_q, finished_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;
  slot_t              rd_q;
  slot_t              mem [Window];

  logic               out_free;
  logic               in_accept;
  logic               mem_we;
  logic [SeqW-1:0]    seq_in;
  logic [SeqW-1:0]    diff;
  logic               in_win;
  logic               dup;
  logic [SlotW-1:0]   in_slot;
  logic [SeqW-1:0]    nxt_seq;
  logic [SlotW-1:0]   nxt_slot;
  logic [SlotW-1:0]   nn_slot;
  logic               more;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == ST_IDLE && out_free);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign seq_in   = in_item_i.seq_num[SeqW-1:0];
  assign diff     = seq_in - base_q;
  assign in_win   = (diff != '0) && (diff <= SeqW'(Window));
  assign dup      = (diff == '0) || (diff > SeqW'(SeqSpace - Window));
  assign in_slot  = seq_in[SlotW-1:0];
  assign nxt_seq  = base_q + SeqW'(1);
  assign nxt_slot = nxt_seq[SlotW-1:0];
  assign nn_slot  = nxt_slot + SlotW'(1);
  // The slot just written counts as received for the delivery check.
  assign more     = recv_q[nxt_slot] || (in_slot == nxt_slot);

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    recv_d      = recv_q;
    finished_d  = finished_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && !finished_q) begin
          if (in_win) begin
            mem_we          = 1'b1;
            recv_d[in_slot] = 1'b1;
            out_valid_d     = 1'b1;
            out_d           = '{kind: KIND_ACK, seq_out: in_item_i.seq_num,
                                data_out: '0, end_of_run: !more};
            if (more) begin
              state_d = ST_READ;
            end
          end else if (dup) begin
            out_valid_d = 1'b1;
            out_d       = '{kind: KIND_ACK, seq_out: in_item_i.seq_num,
                            data_out: '0, end_of_run: 1'b1};
          end
        end
        if (cfg_we_i) begin
          base_d = cfg_data_i[SeqW-1:0];
        end
      end
      ST_READ: begin
        state_d = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (out_free) begin
          recv_d[nxt_slot] = 1'b0;
          base_d           = nxt_seq;
          out_valid_d      = 1'b1;
          out_d            = '{kind: KIND_DATA, seq_out: 8'(nxt_seq),
                               data_out: 32'(rd_q.payload), end_of_run: 1'b0};
          if (rd_q.last) begin
            state_d = ST_FIN;
          end else if (recv_q[nn_slot]) begin
            state_d = ST_READ;
          end else begin
            out_d.end_of_run = 1'b1;
            state_d          = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          finished_d  = 1'b1;
          out_valid_d = 1'b1;
          out_d       = '{kind: KIND_FIN, seq_out: 8'(base_q),
                          data_out: '0, end_of_run: 1'b1};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      recv_q      <= '0;
      finished_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      recv_q      <= recv_d;
      finished_q  <= finished_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Payload memory. A read is issued only in ST_READ, never in a write's cycle,
  // so the slot just stored is always seen by the following delivery.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[in_slot] <= '{last: in_item_i.last_flag,
                        payload: in_item_i.payload[PayloadBits-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      rd_q <= mem[nxt_slot];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_read_then_deliver: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q == ST_DELIVER
  ) else $error("memory read not followed by delivery");

  a_deliver_marked: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ || state_q == ST_DELIVER) |-> recv_q[nxt_slot]
  ) else $error("delivery of a slot that is not marked received");

  a_finished_sticky: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    finished_q |=> finished_q && state_q == ST_IDLE
  ) else $error("finished flag dropped or sequencer left idle after fin");

  a_no_result_after_fin: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (finished_q && !out_valid_q) |=> !out_valid_q
  ) else $error("result produced after fin");

endmodule

`default_nettype wire
